// ----- sv/srtf_pkg.sv -----
// Shared widths, types and constants of the SRTF scheduler.
`timescale 1ns / 1ps
package srtf_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam int ARR_W  = 16;
    localparam int RUN_W  = 16;
    localparam int TIME_W = 21;
    localparam int ID_W   = 5;
    localparam int CNT_W  = 5;
    localparam int WQ_W   = 29;
    localparam int SUMT_W = 25;
    localparam int SUMW_W = 33;
    localparam int ENT_W  = ARR_W + RUN_W + RUN_W;
    localparam int Q_SH   = 8;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [SUMT_W-1:0] SUMT_MAX = '1;
    localparam logic [SUMW_W-1:0] SUMW_MAX = '1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic [ID_W-1:0]   task_id;
        logic              switched;
        logic              finished;
        logic [TIME_W-1:0] turnaround;
        logic [WQ_W-1:0]   weighted_turnaround_q8;
        logic [SUMT_W-1:0] total_turnaround;
        logic [SUMW_W-1:0] total_weighted_q8;
        logic [CNT_W-1:0]  completed_count;
        logic              all_done;
    } t_result;

endpackage

// ----- sv/srtf_in_if.sv -----
// Input channel: load or step word with valid/ready handshake.
`timescale 1ns / 1ps
interface srtf_in_if;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [srtf_pkg::ARR_W-1:0] arrival_time;
    logic [srtf_pkg::RUN_W-1:0] run_time;

    modport source (output valid, action, arrival_time, run_time, input ready);
    modport sink (input valid, action, arrival_time, run_time, output ready);
endinterface

// ----- sv/srtf_out_if.sv -----
// Output channel: one result word per step, valid/ready handshake.
`timescale 1ns / 1ps
interface srtf_out_if;
    logic                        valid;
    logic                        ready;
    logic [srtf_pkg::ID_W-1:0]   task_id;
    logic                        switched;
    logic                        finished;
    logic [srtf_pkg::TIME_W-1:0] turnaround;
    logic [srtf_pkg::WQ_W-1:0]   weighted_turnaround_q8;
    logic [srtf_pkg::SUMT_W-1:0] total_turnaround;
    logic [srtf_pkg::SUMW_W-1:0] total_weighted_q8;
    logic [srtf_pkg::CNT_W-1:0]  completed_count;
    logic                        all_done;

    modport source (output valid, task_id, switched, finished, turnaround,
                    weighted_turnaround_q8, total_turnaround, total_weighted_q8,
                    completed_count, all_done, input ready);
    modport sink (input valid, task_id, switched, finished, turnaround,
                  weighted_turnaround_q8, total_turnaround, total_weighted_q8,
                  completed_count, all_done, output ready);
endinterface

// ----- sv/srtf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/srtf_div.sv -----
// Restoring divider, one quotient bit per cycle, for Q8 weighted turnaround.
`timescale 1ns / 1ps
module srtf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [srtf_pkg::WQ_W-1:0]     i_dividend,
    input  logic [srtf_pkg::RUN_W-1:0]    i_divisor,
    output logic [srtf_pkg::WQ_W-1:0]     o_quot,
    output srtf_pkg::t_div_stat           o_stat
);

    localparam int QW  = srtf_pkg::WQ_W;
    localparam int DW  = srtf_pkg::RUN_W;
    localparam int SCW = $clog2(QW + 1);

    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [SCW-1:0] r_cnt, n_cnt;
    logic [DW:0]    r_rem, n_rem;
    logic [QW-1:0]  r_quo, n_quo;
    logic [DW-1:0]  r_dsr, n_dsr;
    logic [DW:0]    rem_sh;
    logic           ge;

    assign rem_sh = {r_rem[DW-1:0], r_quo[QW-1]};
    assign ge     = rem_sh >= {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = SCW'(QW);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? (rem_sh - {1'b0, r_dsr}) : rem_sh;
            n_quo = {r_quo[QW-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == SCW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_quot      = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ----- sv/srtf_task_scheduler_unit.sv -----
// Top level of the shortest-remaining-time-first task scheduler.
//
// Usage:
//   i_in carries words with action, arrival_time and run_time. A load word
//   (action 0) stores the next task (ids 1..MAX_TASKS) and gives no result;
//   loads beyond MAX_TASKS are dropped. A step word (action 1) runs one time
//   unit and gives exactly one result word on o_out.
//   A step makes two passes through the task memory (earliest arrival,
//   then least remaining time), then an update state and a registered output.
//   When the task completes, the bit-serial divider computes the Q8 weighted
//   turnaround. A step with no live task skips the passes and answers from
//   the idle state.
//   One word is in work at a time; i_in.ready is high only when the
//   block is idle and the result register is empty.
//   A stalled o_out holds its word and blocks further input until taken.
//   Reset clears task liveness, counts, time and totals; the task memory
//   is not cleared, no clearing pass is needed.
`timescale 1ns / 1ps
module srtf_task_scheduler_unit #(
    parameter int MAX_TASKS = srtf_pkg::MAX_TASKS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    srtf_in_if.sink      i_in,
    srtf_out_if.source   o_out
);

    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int IW = $clog2(MAX_TASKS);
    localparam int AW = srtf_pkg::ARR_W;
    localparam int RW = srtf_pkg::RUN_W;
    localparam int TW = srtf_pkg::TIME_W;
    localparam int EW = srtf_pkg::ENT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_P1   = 3'd1;
    localparam logic [2:0] S_P2   = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;

    logic [2:0]                   r_state, n_state;
    logic [CW-1:0]                r_loaded, n_loaded;
    logic [CW-1:0]                r_live_cnt, n_live_cnt;
    logic [MAX_TASKS-1:0]         r_live, n_live;
    logic [CW-1:0]                r_idx, n_idx;
    logic                         r_found, n_found;
    logic [IW-1:0]                r_pick_idx, n_pick_idx;
    logic [AW-1:0]                r_pick_arr, n_pick_arr;
    logic [RW-1:0]                r_pick_run, n_pick_run;
    logic [RW-1:0]                r_pick_rem, n_pick_rem;
    logic [TW-1:0]                r_time, n_time;
    logic [CW-1:0]                r_prev, n_prev;
    logic [TW-1:0]                r_turn, n_turn;
    logic [srtf_pkg::SUMT_W-1:0]  r_sum_t, n_sum_t;
    logic [srtf_pkg::SUMW_W-1:0]  r_sum_w, n_sum_w;
    logic [srtf_pkg::CNT_W-1:0]   r_done_cnt, n_done_cnt;
    logic                         r_ovld, n_ovld;
    srtf_pkg::t_result            r_res, n_res;

    logic                         in_fire;
    logic                         we;
    logic [IW-1:0]                waddr;
    logic [EW-1:0]                wdata;
    logic [EW-1:0]                rdata;
    logic [AW-1:0]                rd_arr;
    logic [RW-1:0]                rd_run;
    logic [RW-1:0]                rd_rem;
    logic [RW-1:0]                ld_run;
    logic [IW-1:0]                e_idx;
    logic                         e_ok;
    logic                         take1, take2;
    logic [TW-1:0]                t_max, t_new, turn_new;
    logic [RW-1:0]                rem_m1;
    logic [CW-1:0]                id_full;
    logic                         div_start;
    logic [srtf_pkg::WQ_W-1:0]    div_quot;
    srtf_pkg::t_div_stat          div_stat;
    logic [srtf_pkg::SUMT_W:0]    sum_t_wide;
    logic [srtf_pkg::SUMW_W:0]    sum_w_wide;

    assign in_fire = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE) && !r_ovld;

    assign rd_arr = rdata[EW-1 -: AW];
    assign rd_run = rdata[RW+RW-1 -: RW];
    assign rd_rem = rdata[RW-1:0];
    assign ld_run = (i_in.run_time == '0) ? RW'(1) : i_in.run_time;

    // entry read last cycle is evaluated while the next address is presented
    assign e_idx = IW'(r_idx - 1'b1);
    assign e_ok  = (r_idx != '0) && r_live[e_idx];
    assign take1 = e_ok && (!r_found || rd_arr < r_pick_arr);
    assign take2 = e_ok && (({{(TW-AW){1'b0}}, rd_arr} <= r_time) || rd_arr == r_pick_arr)
                   && rd_rem < r_pick_rem;

    assign t_max    = (r_time < {{(TW-AW){1'b0}}, r_pick_arr}) ?
                      {{(TW-AW){1'b0}}, r_pick_arr} : r_time;
    assign t_new    = (t_max != srtf_pkg::TIME_MAX) ? t_max + 1'b1 : t_max;
    assign turn_new = t_new - {{(TW-AW){1'b0}}, r_pick_arr};
    assign rem_m1   = r_pick_rem - 1'b1;
    assign id_full  = CW'(r_pick_idx) + 1'b1;

    assign we    = (in_fire && i_in.action == srtf_pkg::ACT_LOAD
                    && r_loaded < CW'(MAX_TASKS)) || (r_state == S_UPD);
    assign waddr = (r_state == S_UPD) ? r_pick_idx : r_loaded[IW-1:0];
    assign wdata = (r_state == S_UPD) ? {r_pick_arr, r_pick_run, rem_m1}
                                      : {i_in.arrival_time, ld_run, ld_run};

    assign div_start = (r_state == S_UPD) && (rem_m1 == '0);

    assign sum_t_wide = {1'b0, r_sum_t} + (srtf_pkg::SUMT_W + 1)'(r_turn);
    assign sum_w_wide = {1'b0, r_sum_w} + (srtf_pkg::SUMW_W + 1)'(div_quot);

    srtf_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_TASKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (rdata)
    );

    // divider latches its operands in UPD, so the dividend comes from turn_new
    srtf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({turn_new, {srtf_pkg::Q_SH{1'b0}}}),
        .i_divisor  (r_pick_run),
        .o_quot     (div_quot),
        .o_stat     (div_stat)
    );

    always_comb begin
        n_state    = r_state;
        n_loaded   = r_loaded;
        n_live_cnt = r_live_cnt;
        n_live     = r_live;
        n_idx      = r_idx;
        n_found    = r_found;
        n_pick_idx = r_pick_idx;
        n_pick_arr = r_pick_arr;
        n_pick_run = r_pick_run;
        n_pick_rem = r_pick_rem;
        n_time     = r_time;
        n_prev     = r_prev;
        n_turn     = r_turn;
        n_sum_t    = r_sum_t;
        n_sum_w    = r_sum_w;
        n_done_cnt = r_done_cnt;
        n_ovld     = r_ovld && !o_out.ready;
        n_res      = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.action == srtf_pkg::ACT_LOAD) begin
                        if (r_loaded < CW'(MAX_TASKS)) begin
                            n_live[r_loaded[IW-1:0]] = 1'b1;
                            n_loaded   = r_loaded + 1'b1;
                            n_live_cnt = r_live_cnt + 1'b1;
                        end
                    end else if (r_live_cnt == '0) begin
                        n_ovld = 1'b1;
                        n_res.task_id                = '0;
                        n_res.switched               = 1'b0;
                        n_res.finished               = 1'b0;
                        n_res.turnaround             = '0;
                        n_res.weighted_turnaround_q8 = '0;
                        n_res.total_turnaround       = r_sum_t;
                        n_res.total_weighted_q8      = r_sum_w;
                        n_res.completed_count        = r_done_cnt;
                        n_res.all_done               = 1'b1;
                    end else begin
                        n_state = S_P1;
                        n_idx   = '0;
                        n_found = 1'b0;
                    end
                end
            end
            S_P1: begin
                if (take1) begin
                    n_found    = 1'b1;
                    n_pick_idx = e_idx;
                    n_pick_arr = rd_arr;
                    n_pick_run = rd_run;
                    n_pick_rem = rd_rem;
                end
                if (r_idx == r_loaded) begin
                    n_idx   = '0;
                    n_state = S_P2;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_P2: begin
                if (take2) begin
                    n_pick_idx = e_idx;
                    n_pick_arr = rd_arr;
                    n_pick_run = rd_run;
                    n_pick_rem = rd_rem;
                end
                if (r_idx == r_loaded) begin
                    n_state = S_UPD;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_UPD: begin
                n_time = t_new;
                n_prev = id_full;
                n_turn = turn_new;
                n_res.task_id  = srtf_pkg::ID_W'(id_full);
                n_res.switched = (r_prev != id_full);
                if (rem_m1 == '0) begin
                    n_live[r_pick_idx] = 1'b0;
                    n_live_cnt = r_live_cnt - 1'b1;
                    n_state    = S_DIV;
                end else begin
                    n_ovld  = 1'b1;
                    n_state = S_IDLE;
                    n_res.finished               = 1'b0;
                    n_res.turnaround             = '0;
                    n_res.weighted_turnaround_q8 = '0;
                    n_res.total_turnaround       = r_sum_t;
                    n_res.total_weighted_q8      = r_sum_w;
                    n_res.completed_count        = r_done_cnt;
                    n_res.all_done               = (r_live_cnt == '0);
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_sum_t = sum_t_wide[srtf_pkg::SUMT_W] ? srtf_pkg::SUMT_MAX
                                                           : sum_t_wide[srtf_pkg::SUMT_W-1:0];
                    n_sum_w = sum_w_wide[srtf_pkg::SUMW_W] ? srtf_pkg::SUMW_MAX
                                                           : sum_w_wide[srtf_pkg::SUMW_W-1:0];
                    n_done_cnt = r_done_cnt + 1'b1;
                    n_ovld     = 1'b1;
                    n_state    = S_IDLE;
                    n_res.finished               = 1'b1;
                    n_res.turnaround             = r_turn;
                    n_res.weighted_turnaround_q8 = div_quot;
                    n_res.total_turnaround       = n_sum_t;
                    n_res.total_weighted_q8      = n_sum_w;
                    n_res.completed_count        = n_done_cnt;
                    n_res.all_done               = (r_live_cnt == '0);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_loaded   <= '0;
            r_live_cnt <= '0;
            r_live     <= '0;
            r_idx      <= '0;
            r_found    <= 1'b0;
            r_time     <= '0;
            r_prev     <= '0;
            r_sum_t    <= '0;
            r_sum_w    <= '0;
            r_done_cnt <= '0;
            r_ovld     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_loaded   <= n_loaded;
            r_live_cnt <= n_live_cnt;
            r_live     <= n_live;
            r_idx      <= n_idx;
            r_found    <= n_found;
            r_time     <= n_time;
            r_prev     <= n_prev;
            r_sum_t    <= n_sum_t;
            r_sum_w    <= n_sum_w;
            r_done_cnt <= n_done_cnt;
            r_ovld     <= n_ovld;
        end
        r_pick_idx <= n_pick_idx;
        r_pick_arr <= n_pick_arr;
        r_pick_run <= n_pick_run;
        r_pick_rem <= n_pick_rem;
        r_turn     <= n_turn;
        r_res      <= n_res;
    end

    assign o_out.valid                  = r_ovld;
    assign o_out.task_id                = r_res.task_id;
    assign o_out.switched               = r_res.switched;
    assign o_out.finished               = r_res.finished;
    assign o_out.turnaround             = r_res.turnaround;
    assign o_out.weighted_turnaround_q8 = r_res.weighted_turnaround_q8;
    assign o_out.total_turnaround       = r_res.total_turnaround;
    assign o_out.total_weighted_q8      = r_res.total_weighted_q8;
    assign o_out.completed_count        = r_res.completed_count;
    assign o_out.all_done               = r_res.all_done;

`ifndef NO_ASSERTIONS
    a_live_le_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live_cnt <= r_loaded)
        else $error("live task count exceeds loaded count");

    a_all_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.all_done) |-> (r_live_cnt == '0))
        else $error("all_done reported with live tasks remaining");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside of its wait state");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");
`endif

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench of the SRTF scheduler: directed and random load/step words.
`timescale 1ns / 1ps
module testbench;

    localparam int NTASK          = srtf_pkg::MAX_TASKS_DEF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLDOFF_CYCLES = 300;

    logic clk;
    logic rst_n;

    srtf_in_if  in_bus ();
    srtf_out_if out_bus ();

    srtf_task_scheduler_unit #(.MAX_TASKS(NTASK)) uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // scheduler state as the testbench tracks it
    logic [srtf_pkg::ARR_W-1:0]  slot_arrival [NTASK];
    logic [srtf_pkg::RUN_W-1:0]  slot_run     [NTASK];
    logic [srtf_pkg::RUN_W-1:0]  slot_left    [NTASK];
    bit                          slot_live    [NTASK];
    int                          tasks_loaded;
    logic [srtf_pkg::TIME_W-1:0] sched_time;
    logic [srtf_pkg::ID_W-1:0]   last_id;
    logic [srtf_pkg::SUMT_W-1:0] turn_sum;
    logic [srtf_pkg::SUMW_W-1:0] weight_sum;
    logic [srtf_pkg::CNT_W-1:0]  done_total;
    srtf_pkg::t_result           sched_forecast [$];

    int words_sent;
    int loads_sent;
    int steps_sent;
    int results_seen;
    int finishes_seen;
    int mismatches;
    bit steady_flow;
    int holdoff_left;
    int sink_wait;

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
                 results_seen, what, got, want);
    endtask

    task automatic compare_field(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            flag_mismatch(what, got, want);
    endtask

    task automatic forecast_word(input logic act, input logic [srtf_pkg::ARR_W-1:0] arr,
                                 input logic [srtf_pkg::RUN_W-1:0] run);
        int                base;
        int                pick;
        srtf_pkg::t_result r;
        logic [63:0]       wide;
        bit                any_live;
        if (act == srtf_pkg::ACT_LOAD) begin
            if (tasks_loaded < NTASK) begin
                slot_arrival[tasks_loaded] = arr;
                slot_run[tasks_loaded]     = (run == '0) ? srtf_pkg::RUN_W'(1) : run;
                slot_left[tasks_loaded]    = slot_run[tasks_loaded];
                slot_live[tasks_loaded]    = 1'b1;
                tasks_loaded++;
            end
        end else begin
            r    = '0;
            base = -1;
            for (int i = 0; i < NTASK; i++)
                if (slot_live[i] && (base < 0 || slot_arrival[i] < slot_arrival[base]))
                    base = i;
            if (base >= 0) begin
                pick = base;
                for (int i = 0; i < NTASK; i++)
                    if (slot_live[i]
                        && (srtf_pkg::TIME_W'(slot_arrival[i]) <= sched_time
                            || slot_arrival[i] == slot_arrival[pick])
                        && slot_left[i] < slot_left[pick])
                        pick = i;
                r.task_id  = srtf_pkg::ID_W'(pick + 1);
                r.switched = (last_id != r.task_id);
                last_id    = r.task_id;
                slot_left[pick]--;
                if (sched_time < srtf_pkg::TIME_W'(slot_arrival[pick]))
                    sched_time = srtf_pkg::TIME_W'(slot_arrival[pick]);
                if (sched_time < srtf_pkg::TIME_MAX)
                    sched_time++;
                if (slot_left[pick] == '0) begin
                    r.finished   = 1'b1;
                    r.turnaround = sched_time - srtf_pkg::TIME_W'(slot_arrival[pick]);
                    wide = (64'(r.turnaround) << srtf_pkg::Q_SH) / 64'(slot_run[pick]);
                    r.weighted_turnaround_q8 = srtf_pkg::WQ_W'(wide);
                    wide = 64'(turn_sum) + 64'(r.turnaround);
                    turn_sum = (wide > 64'(srtf_pkg::SUMT_MAX)) ? srtf_pkg::SUMT_MAX
                                                                : srtf_pkg::SUMT_W'(wide);
                    wide = 64'(weight_sum) + 64'(r.weighted_turnaround_q8);
                    weight_sum = (wide > 64'(srtf_pkg::SUMW_MAX)) ? srtf_pkg::SUMW_MAX
                                                                  : srtf_pkg::SUMW_W'(wide);
                    done_total++;
                    slot_live[pick] = 1'b0;
                end
            end
            any_live = 1'b0;
            for (int i = 0; i < NTASK; i++)
                if (slot_live[i])
                    any_live = 1'b1;
            r.total_turnaround  = turn_sum;
            r.total_weighted_q8 = weight_sum;
            r.completed_count   = done_total;
            r.all_done          = !any_live;
            sched_forecast.push_back(r);
        end
    endtask

    function automatic int pick_gap();
        int roll;
        if (steady_flow)
            return 0;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            return $urandom_range(12, 50);
        if (roll < 9)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    // called at a rising edge; returns at the edge that accepts the word
    task automatic offer_word(input logic act, input logic [srtf_pkg::ARR_W-1:0] arr,
                              input logic [srtf_pkg::RUN_W-1:0] run);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid        <= 1'b1;
        in_bus.action       <= act;
        in_bus.arrival_time <= arr;
        in_bus.run_time     <= run;
        do @(negedge clk); while (!in_bus.ready);
        @(posedge clk);
        words_sent++;
        if (act == srtf_pkg::ACT_LOAD)
            loads_sent++;
        else
            steps_sent++;
        forecast_word(act, arr, run);
    endtask

    task automatic load_task(input logic [srtf_pkg::ARR_W-1:0] arr,
                             input logic [srtf_pkg::RUN_W-1:0] run);
        offer_word(srtf_pkg::ACT_LOAD, arr, run);
    endtask

    task automatic run_step();
        offer_word(srtf_pkg::ACT_STEP, srtf_pkg::ARR_W'($urandom),
                   srtf_pkg::RUN_W'($urandom));
    endtask

    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        while (sched_forecast.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // arrival near the current time, sometimes in the past; mostly short jobs
    task automatic load_random_task();
        int now;
        int arr;
        int run;
        now = (sched_time > 60000) ? 60000 : int'(sched_time);
        if ($urandom_range(0, 3) == 0)
            arr = $urandom_range(0, now);
        else
            arr = now + $urandom_range(0, 24);
        if ($urandom_range(0, 5) == 0)
            run = $urandom_range(31, 300);
        else
            run = $urandom_range(0, 30);
        load_task(srtf_pkg::ARR_W'(arr), srtf_pkg::RUN_W'(run));
    endtask

    task automatic test_idle_steps();
        repeat (2) run_step();
    endtask

    // zero run time, equal arrivals, time jump to a future arrival
    task automatic test_jump_and_ties();
        load_task(16'd3, 16'd0);
        load_task(16'd3, 16'd2);
        load_task(16'd8, 16'd1);
        repeat (5) run_step();
    endtask

    // equal remaining keeps the baseline; a later, shorter arrival preempts it
    task automatic test_preemption();
        load_task(16'd30, 16'd4);
        load_task(16'd30, 16'd4);
        load_task(16'd31, 16'd2);
        repeat (11) run_step();
        wait_drained();
    endtask

    task automatic test_random_mix(input int n_words);
        int burst;
        for (int k = 0; k < n_words; k++) begin
            steady_flow = (k >= 150 && k < 250);
            if (tasks_loaded < NTASK - 2 && $urandom_range(0, 59) == 0) begin
                burst = $urandom_range(1, 3);
                while (burst > 0 && tasks_loaded < NTASK - 2) begin
                    load_random_task();
                    burst--;
                end
            end else begin
                run_step();
            end
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_output_holdoff();
        holdoff_left = HOLDOFF_CYCLES;
        repeat (8) run_step();
        wait_drained();
    endtask

    // fill the table, then keep loading: the surplus must be dropped
    task automatic test_extra_loads(input int n_words);
        while (tasks_loaded < NTASK - 2)
            load_random_task();
        load_task('1, 16'd1);
        load_task('1, '1);
        load_task('0, '0);
        for (int k = 0; k < n_words; k++) begin
            if ($urandom_range(0, 2) == 0)
                load_task(srtf_pkg::ARR_W'($urandom), srtf_pkg::RUN_W'($urandom));
            else
                run_step();
        end
    endtask

    initial begin : sink_proc
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (holdoff_left > 0) begin
                holdoff_left--;
                out_bus.ready <= 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
                if (!steady_flow && $urandom_range(0, 3) == 0)
                    sink_wait = pick_gap();
            end
        end
    end

    // values at the falling edge are the ones taken at the next rising edge
    initial begin : result_check
        srtf_pkg::t_result want;
        forever begin
            @(negedge clk);
            if (rst_n && out_bus.valid && out_bus.ready) begin
                results_seen++;
                if (out_bus.finished)
                    finishes_seen++;
                if (sched_forecast.size() == 0) begin
                    flag_mismatch("unexpected word, task_id", out_bus.task_id, '0);
                end else begin
                    want = sched_forecast.pop_front();
                    compare_field("task_id", out_bus.task_id, want.task_id);
                    compare_field("switched", out_bus.switched, want.switched);
                    compare_field("finished", out_bus.finished, want.finished);
                    compare_field("turnaround", out_bus.turnaround, want.turnaround);
                    compare_field("weighted_turnaround_q8", out_bus.weighted_turnaround_q8,
                                  want.weighted_turnaround_q8);
                    compare_field("total_turnaround", out_bus.total_turnaround,
                                  want.total_turnaround);
                    compare_field("total_weighted_q8", out_bus.total_weighted_q8,
                                  want.total_weighted_q8);
                    compare_field("completed_count", out_bus.completed_count,
                                  want.completed_count);
                    compare_field("all_done", out_bus.all_done, want.all_done);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(negedge clk);
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("srtf_task_scheduler_unit regression: fail");
                $finish;
            end
        end
    end

    initial begin
        rst_n               <= 1'b0;
        in_bus.valid        <= 1'b0;
        in_bus.action       <= srtf_pkg::ACT_LOAD;
        in_bus.arrival_time <= '0;
        in_bus.run_time     <= '0;
        for (int i = 0; i < NTASK; i++) begin
            slot_arrival[i] = '0;
            slot_run[i]     = '0;
            slot_left[i]    = '0;
            slot_live[i]    = 1'b0;
        end
        tasks_loaded  = 0;
        sched_time    = '0;
        last_id       = '0;
        turn_sum      = '0;
        weight_sum    = '0;
        done_total    = '0;
        words_sent    = 0;
        loads_sent    = 0;
        steps_sent    = 0;
        results_seen  = 0;
        finishes_seen = 0;
        mismatches    = 0;
        steady_flow   = 1'b0;
        holdoff_left  = 0;
        sink_wait     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_steps();
        test_jump_and_ties();
        test_preemption();
        test_random_mix(560);
        test_output_holdoff();
        test_extra_loads(250);

        wait_drained();
        repeat (100) @(posedge clk);
        if (sched_forecast.size() != 0)
            flag_mismatch("words never delivered", sched_forecast.size(), '0);

        $display("covered %0d words (%0d loads, %0d steps), %0d results, %0d completions",
                 words_sent, loads_sent, steps_sent, results_seen, finishes_seen);
        $display("incl. idle steps, ties, preemption, dropped loads, %0d-cycle output hold-off",
                 HOLDOFF_CYCLES);
        if (mismatches == 0)
            $display("srtf_task_scheduler_unit regression: pass");
        else
            $display("srtf_task_scheduler_unit regression: fail");
        $finish;
    end

endmodule
